/* hdl/cbts_pkg.sv */
`default_nettype none
package cbts_pkg;

  localparam int unsigned ClkW      = 32;
  localparam int unsigned BaudW     = 20;
  localparam int unsigned PreW      = 4;
  localparam int unsigned WordW     = 15;
  localparam int unsigned QuantaW   = 5;
  localparam int unsigned SegIdxW   = 4;
  localparam int unsigned StepW     = 5;
  localparam int unsigned BaseW     = 10;
  localparam int unsigned Step3W    = 6;
  localparam int unsigned RowW      = 11;
  localparam int unsigned ProdW     = 14;
  localparam int unsigned CntW      = 5;

  localparam logic [PreW-1:0]    PreLast    = 4'd15;
  localparam logic [QuantaW-1:0] QuantaLast = 5'd31;
  localparam logic [SegIdxW-1:0] SegLast    = 4'd14;
  localparam logic [2:0]         SjwLimit   = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_HOLD
  } cbts_state_t;

  // found sits in the lowest bit
  typedef struct packed {
    logic [WordW-1:0] timing_word;
    logic [PreW-1:0]  prescale;
    logic             found;
  } cbts_result_t;

  // seg_idx is the segment total minus three
  function automatic logic [WordW-1:0] timing_word_of(
    input logic [QuantaW-1:0] quanta_m1,
    input logic [SegIdxW-1:0] seg_idx
  );
    logic [2:0] s1;
    logic [2:0] s2;
    logic [1:0] sjw;
    s1  = seg_idx[3:1];
    s2  = 3'(seg_idx - {1'b0, s1});
    sjw = (s1 > SjwLimit) ? SjwLimit[1:0] : s1[1:0];
    return {s2, 1'b0, s1, sjw, 1'b0, quanta_m1};
  endfunction

endpackage
`default_nettype wire

/* hdl/can_bit_timing_search.sv */
`default_nettype none
// Channel   Dir  tdata fields (low bit first)
// s_axis    in   clock_rate[31:0], bit_rate[51:32], zero pad to 56 bits
// m_axis    out  found[0], prescale[4:1], timing_word[19:5], zero pad to 24 bits
//
// A request runs first through a bit-serial divider, then through the search at one
// step per cycle, each step one equality compare against a product built by adds.
// A zero bit rate skips both and goes straight to the hold state with an all-zero result.
// The block takes a new request once the previous one sits in the output
// register, even while that result still waits on m_axis_tready.
// Synchronous active-high reset clears the sequencer and the output valid.
module can_bit_timing_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // clock_rate, bit_rate
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // found, prescale, timing_word
);
  import cbts_pkg::*;

  cbts_state_t  state;
  cbts_state_t  state_next;
  cbts_result_t res;
  cbts_result_t search_res;
  logic [BaudW-1:0] baud;
  logic [ClkW-1:0]  per_bit;
  logic             accept;
  logic             div_start;
  logic             div_done;
  logic             search_done;
  logic             out_load;
  logic             out_free;

  assign baud     = s_axis_tdata[ClkW+BaudW-1:ClkW];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  cbts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_axis_tdata[ClkW-1:0]),
    .divisor  (baud),
    .done     (div_done),
    .quotient (per_bit)
  );

  cbts_search u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (div_done),
    .per_bit(per_bit),
    .done   (search_done),
    .result (search_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (baud == '0) ? ST_HOLD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = s_axis_tvalid && (baud != '0);
      end
      ST_HOLD:   out_load = out_free;
      ST_DIV:    ;
      ST_SEARCH: ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // zero bit rate leaves an all-zero result
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= '0;
    end else if (search_done) begin
      res <= search_res;
    end
    if (out_load) begin
      m_axis_tdata <= {{(24-WordW-PreW-1){1'b0}}, res};
    end
  end

`ifndef SYNTHESIS
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_search_done_state: assert property (@(posedge clk) disable iff (rst)
    search_done |-> state == ST_SEARCH)
    else $error("search finished outside the search phase");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[19:1] == '0)
    else $error("not-found result carries nonzero fields");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("output load did not raise valid");
`endif

endmodule
`default_nettype wire

/* hdl/cbts_divider.sv */
`default_nettype none
module cbts_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [cbts_pkg::ClkW-1:0]  dividend,
  input  wire logic [cbts_pkg::BaudW-1:0] divisor,
  output logic                            done,
  output logic [cbts_pkg::ClkW-1:0]       quotient
);
  import cbts_pkg::*;

  logic                 busy;
  logic [CntW-1:0]      cnt;
  logic [BaudW-1:0]     rem;
  logic [BaudW-1:0]     dvs;
  logic [ClkW-1:0]      work;
  logic [BaudW:0]       trial;
  logic                 ge;
  logic [BaudW:0]       diff;

  assign trial    = {rem, work[ClkW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(ClkW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      work <= dividend;
    end else if (busy) begin
      rem  <= ge ? diff[BaudW-1:0] : trial[BaudW-1:0];
      work <= {work[ClkW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* hdl/cbts_search.sv */
`default_nettype none
module cbts_search (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [cbts_pkg::ClkW-1:0] per_bit,
  output logic                           done,
  output cbts_pkg::cbts_result_t         result
);
  import cbts_pkg::*;

  logic                busy;
  logic [PreW-1:0]     pre;
  logic [QuantaW-1:0]  qm1;
  logic [SegIdxW-1:0]  seg;
  logic [StepW-1:0]    step;
  logic [BaseW-1:0]    base;
  logic [Step3W-1:0]   step3;
  logic [RowW-1:0]     row;
  logic [ProdW-1:0]    prod;

  logic                hit;
  logic [StepW-1:0]    step_inc;
  logic [Step3W-1:0]   step3_inc;
  logic [RowW-1:0]     row_inc;

  assign hit       = per_bit == {{(ClkW-ProdW){1'b0}}, prod};
  assign step_inc  = step + 1'b1;
  assign step3_inc = {step_inc, 1'b0} + Step3W'(step_inc);
  assign row_inc   = row + RowW'(step3);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (hit || (seg == SegLast && qm1 == QuantaLast && pre == PreLast)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // walk prescale, then quanta, then segment total; the product grows by adds
  always_ff @(posedge clk) begin
    if (start) begin
      pre   <= '0;
      qm1   <= '0;
      seg   <= '0;
      step  <= StepW'(1);
      base  <= BaseW'(1);
      step3 <= Step3W'(3);
      row   <= RowW'(3);
      prod  <= ProdW'(3);
    end else if (busy) begin
      if (hit) begin
        result.found       <= 1'b1;
        result.prescale    <= pre;
        result.timing_word <= timing_word_of(qm1, seg);
      end else begin
        result <= '0;
        if (seg != SegLast) begin
          seg  <= seg + 1'b1;
          prod <= prod + ProdW'(base);
        end else if (qm1 != QuantaLast) begin
          qm1  <= qm1 + 1'b1;
          seg  <= '0;
          base <= base + BaseW'(step);
          row  <= row_inc;
          prod <= ProdW'(row_inc);
        end else begin
          pre   <= pre + 1'b1;
          qm1   <= '0;
          seg   <= '0;
          step  <= step_inc;
          base  <= BaseW'(step_inc);
          step3 <= step3_inc;
          row   <= RowW'(step3_inc);
          prod  <= ProdW'(step3_inc);
        end
      end
    end
  end

endmodule
`default_nettype wire
